[hw/rtl/sobc_pkg.sv]
// Shared constants and the side-band record for the sphere/box contact pipeline.
package sobc_pkg;

  localparam int FracBits = 16;
  localparam int SqrtSteps = 32;
  localparam int QuoW = FracBits + 1;
  localparam int DivW = 32 + FracBits;
  localparam int NrmMax = 131071;
  localparam int NrmMin = -131072;

  // Per-item record that rides along the root and divide stages.
  typedef struct packed {
    logic             valid;
    logic             centre_in;
    logic             nohit;
    logic [2:0][31:0] cont;
    logic [2:0][17:0] nrm;
    logic [30:0]      depth;
    logic [30:0]      rad;
    logic [2:0][30:0] rabs;
    logic [2:0]       rneg;
  } meta_t;

endpackage

[hw/rtl/sobc_isqrt.sv]
// Pipelined integer square root, one result bit per stage.
module sobc_isqrt (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  sobc_pkg::meta_t     meta_i,
  input  logic [63:0]         sq_i,
  output sobc_pkg::meta_t     meta_o,
  output logic [31:0]         root_o
);

  localparam int Steps = sobc_pkg::SqrtSteps;

  sobc_pkg::meta_t meta_q [Steps];
  logic [63:0]     n_q    [Steps];
  logic [63:0]     res_q  [Steps];

  for (genvar k = 0; k < Steps; k++) begin : g_step
    localparam logic [63:0] StepBit = 64'd1 << (62 - 2 * k);
    sobc_pkg::meta_t meta_in;
    logic [63:0]     n_in;
    logic [63:0]     res_in;
    logic [63:0]     trial;

    if (k == 0) begin : g_first
      assign meta_in = meta_i;
      assign n_in    = sq_i;
      assign res_in  = '0;
    end else begin : g_next
      assign meta_in = meta_q[k-1];
      assign n_in    = n_q[k-1];
      assign res_in  = res_q[k-1];
    end

    assign trial = res_in + StepBit;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        meta_q[k] <= '0;
      end else if (en_i) begin
        meta_q[k] <= meta_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (n_in >= trial) begin
          n_q[k]   <= n_in - trial;
          res_q[k] <= (res_in >> 1) + StepBit;
        end else begin
          n_q[k]   <= n_in;
          res_q[k] <= res_in >> 1;
        end
      end
    end
  end

  assign meta_o = meta_q[Steps-1];
  assign root_o = res_q[Steps-1][31:0];

endmodule

[hw/rtl/sobc_div.sv]
// Pipelined restoring divider, three lanes of |r| << FracBits over the distance.
module sobc_div (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   en_i,
  input  sobc_pkg::meta_t                        meta_i,
  input  logic [31:0]                            len_i,
  output sobc_pkg::meta_t                        meta_o,
  output logic [31:0]                            len_o,
  output logic [2:0][sobc_pkg::QuoW-1:0]         quo_o
);

  localparam int QuoW = sobc_pkg::QuoW;
  localparam int DivW = sobc_pkg::DivW;
  localparam int FB   = sobc_pkg::FracBits;

  sobc_pkg::meta_t meta_q [QuoW];
  logic [31:0]     len_q  [QuoW];
  logic [DivW-1:0] rem_q  [QuoW][3];
  logic [QuoW-1:0] quo_q  [QuoW][3];

  for (genvar k = 0; k < QuoW; k++) begin : g_step
    sobc_pkg::meta_t meta_in;
    logic [31:0]     len_in;
    logic [DivW-1:0] rem_in [3];
    logic [QuoW-1:0] quo_in [3];
    logic [DivW-1:0] dsh;

    if (k == 0) begin : g_first
      always_comb begin
        meta_in = meta_i;
        len_in  = len_i;
        for (int l = 0; l < 3; l++) begin
          rem_in[l] = DivW'({meta_i.rabs[l], {FB{1'b0}}});
          quo_in[l] = '0;
        end
      end
    end else begin : g_next
      always_comb begin
        meta_in = meta_q[k-1];
        len_in  = len_q[k-1];
        for (int l = 0; l < 3; l++) begin
          rem_in[l] = rem_q[k-1][l];
          quo_in[l] = quo_q[k-1][l];
        end
      end
    end

    assign dsh = DivW'(len_in) << (QuoW - 1 - k);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        meta_q[k] <= '0;
      end else if (en_i) begin
        meta_q[k] <= meta_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        len_q[k] <= len_in;
        for (int l = 0; l < 3; l++) begin
          if (rem_in[l] >= dsh) begin
            rem_q[k][l] <= rem_in[l] - dsh;
            quo_q[k][l] <= {quo_in[l][QuoW-2:0], 1'b1};
          end else begin
            rem_q[k][l] <= rem_in[l];
            quo_q[k][l] <= {quo_in[l][QuoW-2:0], 1'b0};
          end
        end
      end
    end
  end

  assign meta_o = meta_q[QuoW-1];
  assign len_o  = len_q[QuoW-1];
  always_comb begin
    for (int l = 0; l < 3; l++) quo_o[l] = quo_q[QuoW-1][l];
  end

endmodule

[hw/rtl/sphere_oriented_box_contact_unit.sv]
// Sphere against oriented box contact test, fully pipelined, one pair per cycle unless stalled.
//
//  channel | direction | handshake              | payload
//  in      | input     | in_valid_i/in_ready_o  | off_*, radius, half_*, axis_*
//  out     | output    | out_valid_o/out_ready_i| hit, centre_inside, contact_*,
//          |           |                        | normal_*, depth
//
// One transaction enters per cycle while the output is not stalled; most of the
// pipeline is the 32-stage square root and the per-bit divide stages.
// All stages advance together whenever the output register is empty or taken.
// A stalled output holds every stage; nothing is dropped or repeated.
// Reset clears the valid bits and the side-band records; the data registers are not reset.
module sphere_oriented_box_contact_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] off_x_i,
  input  logic signed [31:0] off_y_i,
  input  logic signed [31:0] off_z_i,
  input  logic [30:0]        radius_i,
  input  logic [30:0]        half_x_i,
  input  logic [30:0]        half_y_i,
  input  logic [30:0]        half_z_i,
  input  logic [53:0]        axis_u_i,
  input  logic [53:0]        axis_v_i,
  input  logic [53:0]        axis_w_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               hit_o,
  output logic               centre_inside_o,
  output logic signed [31:0] contact_x_o,
  output logic signed [31:0] contact_y_o,
  output logic signed [31:0] contact_z_o,
  output logic signed [17:0] normal_x_o,
  output logic signed [17:0] normal_y_o,
  output logic signed [17:0] normal_z_o,
  output logic [30:0]        depth_o
);

  localparam int FB   = sobc_pkg::FracBits;
  localparam int QuoW = sobc_pkg::QuoW;
  localparam int NW   = FB + 3;

  logic en;
  logic out_valid_q;
  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  // input unpack
  logic signed [31:0] p_in  [3];
  logic [30:0]        h_in  [3];
  logic signed [17:0] ax_in [3][3];
  always_comb begin
    p_in[0] = off_x_i;
    p_in[1] = off_y_i;
    p_in[2] = off_z_i;
    h_in[0] = half_x_i;
    h_in[1] = half_y_i;
    h_in[2] = half_z_i;
    for (int j = 0; j < 3; j++) begin
      ax_in[0][j] = $signed(axis_u_i[18*j +: 18]);
      ax_in[1][j] = $signed(axis_v_i[18*j +: 18]);
      ax_in[2][j] = $signed(axis_w_i[18*j +: 18]);
    end
  end

  // stage 1: projection products
  logic               v1_q;
  logic signed [31:0] p1_q  [3];
  logic [30:0]        h1_q  [3];
  logic signed [17:0] ax1_q [3][3];
  logic [30:0]        rad1_q;
  logic signed [49:0] pr1_q [3][3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rad1_q <= radius_i;
      for (int i = 0; i < 3; i++) begin
        p1_q[i] <= p_in[i];
        h1_q[i] <= h_in[i];
        for (int j = 0; j < 3; j++) begin
          ax1_q[i][j] <= ax_in[i][j];
          pr1_q[i][j] <= p_in[j] * ax_in[i][j];
        end
      end
    end
  end

  // stage 2: sum and floor shift
  logic               v2_q;
  logic signed [31:0] p2_q  [3];
  logic [30:0]        h2_q  [3];
  logic signed [17:0] ax2_q [3][3];
  logic [30:0]        rad2_q;
  logic signed [51:0] cs2_q [3];
  logic signed [51:0] d2    [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d2[i] = 52'(pr1_q[i][0]) + 52'(pr1_q[i][1]) + 52'(pr1_q[i][2]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rad2_q <= rad1_q;
      p2_q   <= p1_q;
      h2_q   <= h1_q;
      ax2_q  <= ax1_q;
      for (int i = 0; i < 3; i++) cs2_q[i] <= d2[i] >>> FB;
    end
  end

  // stage 3: clamp to the half sizes
  logic               v3_q;
  logic signed [31:0] p3_q  [3];
  logic [30:0]        h3_q  [3];
  logic signed [17:0] ax3_q [3][3];
  logic [30:0]        rad3_q;
  logic signed [31:0] c3_q  [3];
  logic               in3_q;
  logic signed [51:0] cw3   [3];
  logic               in3;

  always_comb begin
    logic signed [51:0] hs;
    in3 = 1'b1;
    for (int i = 0; i < 3; i++) begin
      hs     = $signed(52'(h2_q[i]));
      cw3[i] = cs2_q[i];
      if (cs2_q[i] < -hs) begin
        cw3[i] = -hs;
        in3    = 1'b0;
      end
      if (cs2_q[i] > hs) begin
        cw3[i] = hs;
        in3    = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rad3_q <= rad2_q;
      p3_q   <= p2_q;
      h3_q   <= h2_q;
      ax3_q  <= ax2_q;
      in3_q  <= in3;
      for (int i = 0; i < 3; i++) c3_q[i] <= cw3[i][31:0];
    end
  end

  // stage 4: rotate-back products and face distances
  logic               v4_q;
  logic signed [31:0] p4_q   [3];
  logic signed [17:0] ax4_q  [3][3];
  logic [30:0]        rad4_q;
  logic               in4_q;
  logic signed [49:0] cp4_q  [3][3];
  logic [30:0]        fd4_q  [3];
  logic [2:0]         cpos4_q;
  logic [31:0]        cabs4  [3];

  always_comb begin
    for (int i = 0; i < 3; i++) cabs4[i] = c3_q[i][31] ? 32'(-c3_q[i]) : 32'(c3_q[i]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (en) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rad4_q <= rad3_q;
      p4_q   <= p3_q;
      ax4_q  <= ax3_q;
      in4_q  <= in3_q;
      for (int i = 0; i < 3; i++) begin
        fd4_q[i]   <= h3_q[i] - cabs4[i][30:0];
        cpos4_q[i] <= c3_q[i] > 32'sd0;
        for (int j = 0; j < 3; j++) cp4_q[i][j] <= c3_q[i] * ax3_q[i][j];
      end
    end
  end

  // stage 5: world point, shallowest face
  logic               v5_q;
  logic signed [31:0] p5_q   [3];
  logic [30:0]        rad5_q;
  logic               in5_q;
  logic signed [51:0] q5_q   [3];
  logic [17:0]        nrm5_q [3];
  logic [30:0]        dep5_q;
  logic signed [51:0] qs5    [3];
  logic [17:0]        nrm5   [3];
  logic [30:0]        dep5;

  always_comb begin
    logic [1:0]         best;
    logic [30:0]        bd;
    logic [31:0]        dsum;
    logic signed [17:0] a;
    for (int j = 0; j < 3; j++) begin
      qs5[j] = 52'(cp4_q[0][j]) + 52'(cp4_q[1][j]) + 52'(cp4_q[2][j]);
    end
    best = 2'd0;
    bd   = fd4_q[0];
    if (fd4_q[1] < bd) begin
      best = 2'd1;
      bd   = fd4_q[1];
    end
    if (fd4_q[2] < bd) begin
      best = 2'd2;
      bd   = fd4_q[2];
    end
    for (int j = 0; j < 3; j++) begin
      a = ax4_q[best][j];
      if (cpos4_q[best]) begin
        nrm5[j] = a;
      end else if (a == 18'sh20000) begin
        nrm5[j] = 18'h1FFFF;
      end else begin
        nrm5[j] = -a;
      end
    end
    dsum = {1'b0, bd} + {1'b0, rad4_q};
    dep5 = dsum[31] ? '1 : dsum[30:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else if (en) begin
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rad5_q <= rad4_q;
      p5_q   <= p4_q;
      in5_q  <= in4_q;
      nrm5_q <= nrm5;
      dep5_q <= dep5;
      for (int j = 0; j < 3; j++) q5_q[j] <= qs5[j] >>> FB;
    end
  end

  // stage 6: separation, far rejection, record build
  sobc_pkg::meta_t    meta6_q;
  sobc_pkg::meta_t    meta6;

  always_comb begin
    logic signed [52:0] r;
    logic [52:0]        ra;
    logic               far;
    meta6           = '0;
    meta6.valid     = v5_q;
    meta6.centre_in = in5_q;
    meta6.rad       = rad5_q;
    far             = 1'b0;
    for (int j = 0; j < 3; j++) begin
      r  = 53'(p5_q[j]) - 53'(q5_q[j]);
      ra = r[52] ? 53'(-r) : 53'(r);
      if (ra > 53'(rad5_q)) far = 1'b1;
      meta6.rabs[j] = ra[30:0];
      meta6.rneg[j] = r[52];
    end
    if (in5_q) begin
      for (int j = 0; j < 3; j++) begin
        meta6.cont[j] = p5_q[j];
        meta6.nrm[j]  = nrm5_q[j];
      end
      meta6.depth = dep5_q;
    end else begin
      meta6.nohit = far;
      for (int j = 0; j < 3; j++) begin
        if (q5_q[j] > 52'sh7FFFFFFF) begin
          meta6.cont[j] = 32'h7FFFFFFF;
        end else if (q5_q[j] < -52'sh80000000) begin
          meta6.cont[j] = 32'h80000000;
        end else begin
          meta6.cont[j] = q5_q[j][31:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      meta6_q <= '0;
    end else if (en) begin
      meta6_q <= meta6;
    end
  end

  // stage 7: squares
  sobc_pkg::meta_t meta7_q;
  logic [61:0]     sq7_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      meta7_q <= '0;
    end else if (en) begin
      meta7_q <= meta6_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int j = 0; j < 3; j++) sq7_q[j] <= meta6_q.rabs[j] * meta6_q.rabs[j];
    end
  end

  // stage 8: squared distance
  sobc_pkg::meta_t meta8_q;
  logic [63:0]     s8_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      meta8_q <= '0;
    end else if (en) begin
      meta8_q <= meta7_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s8_q <= 64'(sq7_q[0]) + 64'(sq7_q[1]) + 64'(sq7_q[2]);
    end
  end

  sobc_pkg::meta_t meta_sq;
  logic [31:0]     root;

  sobc_isqrt u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .meta_i (meta8_q),
    .sq_i   (s8_q),
    .meta_o (meta_sq),
    .root_o (root)
  );

  // stage 9: distance against radius
  sobc_pkg::meta_t meta9_q;
  sobc_pkg::meta_t meta9;
  logic [31:0]     len9_q;

  always_comb begin
    meta9 = meta_sq;
    if (!meta_sq.centre_in && !meta_sq.nohit) begin
      if (root > 32'(meta_sq.rad)) begin
        meta9.nohit = 1'b1;
      end
      meta9.depth = meta_sq.rad - root[30:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      meta9_q <= '0;
    end else if (en) begin
      meta9_q <= meta9;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      len9_q <= root;
    end
  end

  sobc_pkg::meta_t             meta_dv;
  logic [31:0]                 len_dv;
  logic [2:0][QuoW-1:0]        quo_dv;

  sobc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .meta_i (meta9_q),
    .len_i  (len9_q),
    .meta_o (meta_dv),
    .len_o  (len_dv),
    .quo_o  (quo_dv)
  );

  // output register
  logic               hit_q;
  logic               inside_q;
  logic signed [31:0] cont_q [3];
  logic signed [17:0] nrm_q  [3];
  logic [30:0]        depth_q;
  logic signed [17:0] nrm_o  [3];

  always_comb begin
    logic signed [NW-1:0] nv;
    logic signed [31:0]   nx;
    for (int j = 0; j < 3; j++) begin
      nv = $signed({2'b00, quo_dv[j]});
      if (meta_dv.rneg[j]) nv = -nv;
      nx = 32'(nv);
      if (meta_dv.centre_in) begin
        nrm_o[j] = meta_dv.nrm[j];
      end else if (len_dv == 32'd0) begin
        nrm_o[j] = '0;
      end else if (nx > 32'(sobc_pkg::NrmMax)) begin
        nrm_o[j] = 18'sh1FFFF;
      end else if (nx < 32'(sobc_pkg::NrmMin)) begin
        nrm_o[j] = 18'sh20000;
      end else begin
        nrm_o[j] = nx[17:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= meta_dv.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      // drop every field on a miss
      hit_q    <= !meta_dv.nohit;
      inside_q <= !meta_dv.nohit && meta_dv.centre_in;
      depth_q  <= meta_dv.nohit ? '0 : meta_dv.depth;
      for (int j = 0; j < 3; j++) begin
        cont_q[j] <= meta_dv.nohit ? '0 : $signed(meta_dv.cont[j]);
        nrm_q[j]  <= meta_dv.nohit ? '0 : nrm_o[j];
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign hit_o           = hit_q;
  assign centre_inside_o = inside_q;
  assign contact_x_o     = cont_q[0];
  assign contact_y_o     = cont_q[1];
  assign contact_z_o     = cont_q[2];
  assign normal_x_o      = nrm_q[0];
  assign normal_y_o      = nrm_q[1];
  assign normal_z_o      = nrm_q[2];
  assign depth_o         = depth_q;

`ifndef SYNTHESIS
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !hit_o |-> !centre_inside_o && depth_o == '0 &&
      contact_x_o == '0 && contact_y_o == '0 && contact_z_o == '0 &&
      normal_x_o == '0 && normal_y_o == '0 && normal_z_o == '0)
    else $error("miss result carries nonzero fields");

  a_inside_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && centre_inside_o |-> hit_o)
    else $error("inside result without hit");

  a_unit_normal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && hit_o && !centre_inside_o |->
      normal_x_o <= 18'sd65536 && normal_x_o >= -18'sd65536 &&
      normal_y_o <= 18'sd65536 && normal_y_o >= -18'sd65536 &&
      normal_z_o <= 18'sd65536 && normal_z_o >= -18'sd65536)
    else $error("outside normal exceeds unit length");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(meta9_q) && $stable(meta8_q))
    else $error("pipeline moved during stall");
`endif

endmodule
